### rtl/local_max_window_sum_hit_finder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the local maximum window sum hit finder
// ---------------------------------------------------------------------------
`ifndef LOCAL_MAX_WINDOW_SUM_HIT_FINDER_DEFINES_SVH
`define LOCAL_MAX_WINDOW_SUM_HIT_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while dis is high
`define LMW_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is high
`define LMW_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lmw_pkg.sv
// ---------------------------------------------------------------------------
// lmw_pkg
// Shared constants, types and helpers of the local maximum hit finder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmw_pkg;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int ENERGY_W = 27;
  localparam int TIME_W   = 10;

  // Record and window geometry
  localparam int RECORD_LENGTH = 1024;
  localparam int HALF_WINDOW   = 3;
  localparam int WIN_LEN       = 2 * HALF_WINDOW + 1;
  localparam int IDX_W         = $clog2(RECORD_LENGTH + 1);

  // Window sum is built as pair sums in the front, finished in the back
  localparam int NPART  = (WIN_LEN + 1) / 2;
  localparam int PART_W = SAMPLE_W + 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(WIN_LEN);
  localparam int SAT_W  = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;

  // Queue depths (powers of two, pointers wrap naturally)
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Energy limits and threshold reset value (10.0 in Q.8)
  localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic signed [ENERGY_W-1:0] THRESHOLD_RESET = ENERGY_W'(2560);

  typedef logic signed [PART_W-1:0] part_t;

  // One tested maximum on its way to the threshold stage
  typedef struct packed {
    logic [TIME_W-1:0]      centre;
    part_t [NPART-1:0]      parts;
  } cand_t;

  // Candidate request between front, queue and back
  typedef struct packed {
    logic  valid;
    cand_t cand;
  } cand_req_t;

  // One finished hit
  typedef struct packed {
    logic [TIME_W-1:0]          hit_time;
    logic signed [ENERGY_W-1:0] hit_energy;
  } hit_t;

  // Clamp a window sum to the energy range
  function automatic logic signed [ENERGY_W-1:0] sat_energy(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [SAT_W-1:0] v;
    v = SAT_W'(s);
    if (v > SAT_W'(E_MAX)) begin
      return E_MAX;
    end else if (v < SAT_W'(E_MIN)) begin
      return E_MIN;
    end else begin
      return ENERGY_W'(v);
    end
  endfunction

endpackage

### rtl/lmw_front.sv
// ---------------------------------------------------------------------------
// lmw_front
// Sample delay line, record index, local maximum test and pair sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmw_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic signed [lmw_pkg::SAMPLE_W-1:0] sample,
  input  logic                              record_start,
  input  logic [lmw_pkg::Q_CNT_W-1:0]       q_count,
  output logic                              full,
  output lmw_pkg::cand_req_t                q_push
);
  import lmw_pkg::*;

  logic signed [SAMPLE_W-1:0] window [WIN_LEN];  // [0] newest
  logic [IDX_W-1:0]           sample_index;
  logic                       f1_valid;
  logic [TIME_W-1:0]          f1_centre;
  logic                       accept;
  logic [IDX_W-1:0]           idx_cur;
  logic                       is_max;
  cand_t                      cand;

  // Hold off requests while the queue plus the test stage could overflow
  assign full   = ({1'b0, q_count} + (Q_CNT_W+1)'(f1_valid)) >= (Q_CNT_W+1)'(Q_DEPTH);
  assign accept = push && !full;
  assign idx_cur = record_start ? '0 : sample_index;

  // Delay line
  always_ff @(posedge clk) begin
    if (accept) begin
      window[0] <= sample;
      for (int k = 1; k < WIN_LEN; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  // Record index; saturates at the record length until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      f1_valid     <= 1'b0;
    end else begin
      f1_valid <= 1'b0;
      if (accept && (idx_cur < IDX_W'(RECORD_LENGTH))) begin
        sample_index <= idx_cur + 1'b1;
        f1_valid     <= idx_cur >= IDX_W'(2 * HALF_WINDOW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_centre <= TIME_W'(idx_cur - IDX_W'(HALF_WINDOW));
    end
  end

  // Local maximum test and pair sums on the full window
  always_comb begin
    is_max      = 1'b1;
    cand.centre = f1_centre;
    for (int k = 0; k < WIN_LEN; k++) begin
      if (window[HALF_WINDOW] < window[k]) begin
        is_max = 1'b0;
      end
    end
    for (int p = 0; p < NPART; p++) begin
      if (2 * p + 1 < WIN_LEN) begin
        cand.parts[p] = PART_W'(window[2*p]) + PART_W'(window[2*p+1]);
      end else begin
        cand.parts[p] = PART_W'(window[2*p]);
      end
    end
  end

  assign q_push.valid = f1_valid && is_max;
  assign q_push.cand  = cand;

endmodule

### rtl/lmw_cand_queue.sv
// ---------------------------------------------------------------------------
// lmw_cand_queue
// Short queue of local maximum candidates between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmw_cand_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  lmw_pkg::cand_req_t          push_req,
  input  logic                        pop,
  output lmw_pkg::cand_req_t          head,
  output logic [lmw_pkg::Q_CNT_W-1:0] count
);
  import lmw_pkg::*;

  cand_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic               do_pop;

  // Front never pushes into a full queue (credit held there)
  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (push_req.valid) begin
      mem[wr_ptr] <= push_req.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_req.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_req.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = count != '0;
  assign head.cand  = mem[rd_ptr];

endmodule

### rtl/lmw_back.sv
// ---------------------------------------------------------------------------
// lmw_back
// Window sum, threshold test and result queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmw_back (
  input  logic                                clk,
  input  logic                                rst,
  input  lmw_pkg::cand_req_t                  head,
  output logic                                q_pop,
  input  logic signed [lmw_pkg::ENERGY_W-1:0] threshold,
  input  logic                                pop,
  output logic                                empty,
  output logic [lmw_pkg::TIME_W-1:0]          hit_time,
  output logic signed [lmw_pkg::ENERGY_W-1:0] hit_energy
);
  import lmw_pkg::*;

  logic                       s1_valid;
  logic [TIME_W-1:0]          s1_time;
  logic signed [ENERGY_W-1:0] s1_energy;
  logic signed [SUM_W-1:0]    sum;
  hit_t                       mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]       wr_ptr;
  logic [OUT_PTR_W-1:0]       rd_ptr;
  logic [OUT_CNT_W-1:0]       out_count;
  logic                       room;
  logic                       out_push;
  logic                       out_pop;

  // Take a candidate only if the result queue has a slot for it
  assign room  = ({1'b0, out_count} + (OUT_CNT_W+1)'(s1_valid)) < (OUT_CNT_W+1)'(OUT_DEPTH);
  assign q_pop = head.valid && room;

  // Finish the window sum
  always_comb begin
    sum = '0;
    for (int p = 0; p < NPART; p++) begin
      sum = sum + SUM_W'($signed(head.cand.parts[p]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_time   <= head.cand.centre;
      s1_energy <= sat_energy(sum);
    end
  end

  // Threshold test, strictly greater
  assign out_push = s1_valid && (s1_energy > threshold);
  assign out_pop  = pop && !empty;

  // Result queue
  always_ff @(posedge clk) begin
    if (out_push) begin
      mem[wr_ptr] <= '{hit_time: s1_time, hit_energy: s1_energy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({out_push, out_pop})
        2'b10:   out_count <= out_count + 1'b1;
        2'b01:   out_count <= out_count - 1'b1;
        default: out_count <= out_count;
      endcase
    end
  end

  assign empty      = out_count == '0;
  assign hit_time   = mem[rd_ptr].hit_time;
  assign hit_energy = mem[rd_ptr].hit_energy;

endmodule

### rtl/local_max_window_sum_hit_finder.sv
// ---------------------------------------------------------------------------
// local_max_window_sum_hit_finder
// Finds local maxima over a 7-sample window and reports those whose window
// sum exceeds a programmable threshold.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue side: drive sample/record_start with push; a request is taken
//   when push is high and full is low. record_start marks a record's first
//   sample. One sample per cycle is sustained while full stays low.
//   Result queue side: while empty is low, hit_time/hit_energy show the oldest
//   hit; pop takes it. At most one hit per sample.
//   A hit belongs to the sample that completes its window (three samples after
//   the centre) and reaches the result ports through the test stage, candidate
//   queue, sum stage and result queue.
//   Throughput is one sample per cycle while full is low, set by the delay line
//   that shifts once per request; full rises only when both queues back up.
//   When pop stays low, the result queue (4 deep) fills, then the candidate
//   queue (4 deep), then full rises; nothing is dropped.
//   cfg_write/cfg_data load the signed Q.8 threshold (reset 10.0); write it
//   only while the block is idle.
//   rst (synchronous) empties both queues and starts a new record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module local_max_window_sum_hit_finder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [lmw_pkg::SAMPLE_W-1:0] sample,
  input  logic                                record_start,
  output logic                                empty,
  input  logic                                pop,
  output logic [lmw_pkg::TIME_W-1:0]          hit_time,
  output logic signed [lmw_pkg::ENERGY_W-1:0] hit_energy,
  input  logic                                cfg_write,
  input  logic signed [lmw_pkg::ENERGY_W-1:0] cfg_data
);
  import lmw_pkg::*;

  logic signed [ENERGY_W-1:0] hit_threshold;
  cand_req_t                  q_push;
  cand_req_t                  q_head;
  logic [Q_CNT_W-1:0]         q_count;
  logic                       q_pop;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      hit_threshold <= cfg_data;
    end
  end

  lmw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .sample       (sample),
    .record_start (record_start),
    .q_count      (q_count),
    .full         (full),
    .q_push       (q_push)
  );

  lmw_cand_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (q_push),
    .pop      (q_pop),
    .head     (q_head),
    .count    (q_count)
  );

  lmw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_pop      (q_pop),
    .threshold  (hit_threshold),
    .pop        (pop),
    .empty      (empty),
    .hit_time   (hit_time),
    .hit_energy (hit_energy)
  );

endmodule

### rtl/lmw_checker.sv
// ---------------------------------------------------------------------------
// lmw_checker
// Port-level checks of the hit finder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "local_max_window_sum_hit_finder_defines.svh"

module lmw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic [lmw_pkg::TIME_W-1:0]          hit_time,
  input logic signed [lmw_pkg::ENERGY_W-1:0] hit_energy
);
  import lmw_pkg::*;

  // Reset leaves both queues empty
  `LMW_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, empty && !full, "queues not empty after reset")

  // A waiting hit stays put until it is popped
  `LMW_ASSERT_NEXT(a_hit_holds, clk, rst, !empty && !pop, !empty && $stable(hit_time) && $stable(hit_energy), "waiting hit changed")

  // Centres are never within half a window of a record edge
  `LMW_ASSERT_IMP(a_time_range, clk, rst, !empty, (hit_time >= TIME_W'(HALF_WINDOW)) && (hit_time <= TIME_W'(RECORD_LENGTH - 1 - HALF_WINDOW)), "hit centre too close to a record edge")

endmodule

bind local_max_window_sum_hit_finder lmw_checker u_checker (.*);
